>>> hdl/zs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zs_pkg
// shared widths, constants, action codes and control structs of the sampler
// ----------------------------------------------------------------------------
package zs_pkg;

  localparam int unsigned TABLE_SIZE_DEF = 65536;
  localparam int unsigned STREAMS_DEF    = 32;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned STREAM_W = 5;
  localparam int unsigned ENTRY_W  = 16;
  localparam int unsigned WORD_W   = 31;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MUL_W    = 15;
  localparam int unsigned PROD_W   = WORD_W + MUL_W;

  localparam logic [MUL_W-1:0]  LCG_MUL = 15'd16807;
  localparam logic [WORD_W-1:0] LCG_MOD = 31'h7FFF_FFFF;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD = 2'd0,
    ACT_SEED = 2'd1,
    ACT_DRAW = 2'd2
  } action_e;

  typedef struct packed {
    logic                draw;
    logic                seed;
    logic [STREAM_W-1:0] stream;
    logic [WORD_W-1:0]   seed_val;
  } gen_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] x;
  } gen_rsp_t;

  typedef struct packed {
    logic               load;
    logic               start;
    logic [ENTRY_W-1:0] addr;
    logic [WORD_W-1:0]  data;
  } srch_req_t;

  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] index;
  } srch_rsp_t;

endpackage

>>> hdl/zs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zs_if
// valid/ready channels for request and sample transactions
// ----------------------------------------------------------------------------
interface zs_in_if;
  import zs_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [STREAM_W-1:0] stream;
  logic [ENTRY_W-1:0]  entry_index;
  logic [WORD_W-1:0]   data_word;

  modport source (output valid, action, stream, entry_index, data_word, input ready);
  modport sink   (input valid, action, stream, entry_index, data_word, output ready);
endinterface

interface zs_out_if;
  import zs_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic [STREAM_W-1:0] stream_out;

  modport source (output valid, sample, stream_out, input ready);
  modport sink   (input valid, sample, stream_out, output ready);
endinterface

>>> hdl/zs_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zs_gen
// per-stream generator state memory with read, multiply, fold and write back
// ----------------------------------------------------------------------------
module zs_gen #(
  parameter int unsigned STREAMS = zs_pkg::STREAMS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  zs_pkg::gen_req_t req_i,
  output zs_pkg::gen_rsp_t rsp_o
);
  import zs_pkg::*;

  localparam int unsigned SW = (STREAMS > 1) ? $clog2(STREAMS) : 1;

  logic [WORD_W-1:0] state_mem [STREAMS];
  logic [STREAMS-1:0] vld_q;
  logic [SW-1:0]      idx, idx_q, waddr;
  logic [WORD_W-1:0]  rdata_q, x_cur, x_new, wdata;
  logic               hit_q, rd_q, mul_q, we;
  logic [PROD_W-1:0]  prod_d, prod_q;
  logic [WORD_W:0]    sum;

  assign idx   = SW'(req_i.stream);
  assign we    = req_i.seed | mul_q;
  assign waddr = mul_q ? idx_q : idx;
  assign wdata = mul_q ? x_new : req_i.seed_val;

  always_ff @(posedge clk_i) begin
    if (we) begin
      state_mem[waddr] <= wdata;
    end
    rdata_q <= state_mem[idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
      rd_q  <= 1'b0;
      mul_q <= 1'b0;
      idx_q <= '0;
    end else begin
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      hit_q <= vld_q[idx];
      rd_q  <= req_i.draw;
      mul_q <= rd_q;
      if (req_i.draw) begin
        idx_q <= idx;
      end
    end
  end

  // never-written streams start at one
  assign x_cur  = hit_q ? rdata_q : WORD_W'(1);
  assign prod_d = x_cur * LCG_MUL;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // mersenne fold, a sum equal to the modulus stays as is
  assign sum   = {1'b0, prod_q[WORD_W-1:0]} + (WORD_W + 1)'(prod_q[PROD_W-1:WORD_W]);
  assign x_new = (sum > {1'b0, LCG_MOD}) ? WORD_W'(sum - {1'b0, LCG_MOD}) : sum[WORD_W-1:0];

  assign rsp_o.done = mul_q;
  assign rsp_o.x    = x_new;

endmodule

>>> hdl/zs_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zs_search
// threshold table memory and binary search, one table read per cycle
// ----------------------------------------------------------------------------
module zs_search #(
  parameter int unsigned TABLE_SIZE = zs_pkg::TABLE_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  zs_pkg::srch_req_t req_i,
  output zs_pkg::srch_rsp_t rsp_o
);
  import zs_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_SIZE);
  localparam int unsigned CW = IW + 1;
  localparam logic [IW-1:0] MID0 = IW'((TABLE_SIZE - 1) / 2);

  logic [WORD_W-1:0]   thr_mem [TABLE_SIZE];
  logic [WORD_W-1:0]   rdata_q, x_q;
  logic [IW-1:0]       raddr;
  logic [CW-1:0]       low_q, hp1_q, mid_q, low_n, hp1_n, mid_n, res;
  logic [CW:0]         mid_sum;
  logic                busy_q, done_q, lt, cont;
  logic [SAMPLE_W-1:0] index_q;

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      thr_mem[IW'(req_i.addr)] <= req_i.data;
    end
    rdata_q <= thr_mem[raddr];
  end

  // hp1 is one above the upper bound of the search window
  assign lt      = x_q < rdata_q;
  assign low_n   = lt ? low_q : mid_q + CW'(1);
  assign hp1_n   = lt ? mid_q : hp1_q;
  assign cont    = low_n < hp1_n;
  assign mid_sum = {1'b0, low_n} + {1'b0, hp1_n} - (CW + 1)'(1);
  assign mid_n   = mid_sum[CW:1];
  assign raddr   = req_i.start ? MID0 : mid_n[IW-1:0];
  assign res     = (hp1_n == '0) ? '0 : hp1_n - CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      low_q  <= '0;
      hp1_q  <= '0;
      mid_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        low_q  <= '0;
        hp1_q  <= CW'(TABLE_SIZE);
        mid_q  <= {1'b0, MID0};
      end else if (busy_q) begin
        low_q <= low_n;
        hp1_q <= hp1_n;
        mid_q <= mid_n;
        if (!cont) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q <= req_i.data;
    end
    if (busy_q && !cont) begin
      index_q <= SAMPLE_W'(res);
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.index = index_q;

endmodule

>>> hdl/zipf_sampler_lcg_cdf_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zipf_sampler_lcg_cdf_search
// zipf sampler: park-miller generator per stream and inverse cdf table search
// ----------------------------------------------------------------------------
// Load and seed transactions: a load writes one threshold into the table
// memory, a seed writes a stream's generator state (a zero seed is dropped).
// A draw reads the stream's state from its memory, multiplies by 16807 and
// folds modulo 2^31-1 through a read register and a product register,
// writes the new state back, then binary-searches the threshold table with
// one memory read per cycle, and moves the found index through a result
// register into the output register once that is free or being read. One
// request is in flight at a time; the next is taken once the sample sits in
// the output register. Draws and seeds on streams at or above STREAMS, loads
// at or above TABLE_SIZE and action code 3 are dropped without a sample.
// Table entries read by a search must have been loaded first.
// ----------------------------------------------------------------------------
module zipf_sampler_lcg_cdf_search #(
  parameter int unsigned TABLE_SIZE = zs_pkg::TABLE_SIZE_DEF,
  parameter int unsigned STREAMS    = zs_pkg::STREAMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  zs_in_if.sink       in_i,
  zs_out_if.source    out_o
);
  import zs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_GEN  = 4'b0010,
    ST_SRCH = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic                acc, stream_ok, entry_ok, is_load, is_seed, is_draw, draw_go;
  logic                out_load, out_valid_q;
  logic [STREAM_W-1:0] stream_q, stream_out_q;
  logic [SAMPLE_W-1:0] result_q, sample_q;
  gen_req_t            gen_req;
  gen_rsp_t            gen_rsp;
  srch_req_t           srch_req;
  srch_rsp_t           srch_rsp;

  assign in_i.ready = (state_q == ST_IDLE);
  assign acc        = in_i.valid & in_i.ready;
  assign stream_ok  = 32'(in_i.stream) < 32'(STREAMS);
  assign entry_ok   = 32'(in_i.entry_index) < 32'(TABLE_SIZE);
  assign is_load    = (in_i.action == ACT_LOAD);
  assign is_seed    = (in_i.action == ACT_SEED);
  assign is_draw    = (in_i.action == ACT_DRAW);
  assign draw_go    = acc & is_draw & stream_ok;

  assign gen_req.draw     = draw_go;
  assign gen_req.seed     = acc & is_seed & stream_ok & (in_i.data_word != '0);
  assign gen_req.stream   = in_i.stream;
  assign gen_req.seed_val = in_i.data_word;

  assign srch_req.load  = acc & is_load & entry_ok;
  assign srch_req.start = (state_q == ST_GEN) & gen_rsp.done;
  assign srch_req.addr  = in_i.entry_index;
  assign srch_req.data  = srch_req.start ? gen_rsp.x : in_i.data_word;

  zs_gen #(
    .STREAMS (STREAMS)
  ) u_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (gen_req),
    .rsp_o  (gen_rsp)
  );

  zs_search #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (srch_req),
    .rsp_o  (srch_rsp)
  );

  assign out_load = (state_q == ST_OUT) & (!out_valid_q | out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (draw_go) begin
          state_d = ST_GEN;
        end
      end
      ST_GEN: begin
        if (gen_rsp.done) begin
          state_d = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (srch_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw_go) begin
      stream_q <= in_i.stream;
    end
    if (srch_rsp.done) begin
      result_q <= srch_rsp.index;
    end
    if (out_load) begin
      sample_q     <= result_q;
      stream_out_q <= stream_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample     = sample_q;
  assign out_o.stream_out = stream_out_q;

  // generator step finishes only while a draw waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_rsp.done |-> (state_q == ST_GEN))
    else $error("generator result outside of a draw");

  // search finishes only while the search state is active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_rsp.done |-> (state_q == ST_SRCH))
    else $error("search result outside of a search");

  // an accepted draw on a valid stream starts the generator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_go |=> (state_q == ST_GEN))
    else $error("accepted draw did not start");

  // a search never starts while a transaction can be accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_req.start |-> !in_i.ready)
    else $error("search start while idle");

endmodule
